// ===== hdl/xxh_pkg.sv =====
// shared types, constants and helpers of the xxh64 stream hash unit
package xxh_pkg;

  localparam logic [63:0] P1 = 64'h9E3779B185EBCA87;
  localparam logic [63:0] P2 = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] P3 = 64'h165667B19E3779F9;
  localparam logic [63:0] P4 = 64'h85EBCA77C2B2AE63;
  localparam logic [63:0] P5 = 64'h27D4EB2F165667C5;

  localparam logic [3:0] FULL_WORD_BYTES = 4'd8;

  // one classified message word as queued between front and back
  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last;
  } item_t;

  // operand request to the shared multiplier
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  // rotate left by a fixed amount
  function automatic logic [63:0] rotl(input logic [63:0] v, input int s);
    rotl = (v << s) | (v >> (64 - s));
  endfunction

endpackage

// ===== hdl/xxh_front.sv =====
// input queue: accepts message words, saturates byte counts, buffers them
module xxh_front #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  logic [63:0]   in_data_word,
  input  logic [3:0]    in_valid_bytes,
  input  logic          in_last,
  output logic          q_valid,
  output xxh_pkg::item_t q_item,
  input  logic          q_pop
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  xxh_pkg::item_t   mem_r [DEPTH];
  logic [AW-1:0]    wptr_r, rptr_r;
  logic [CW-1:0]    count_r;
  xxh_pkg::item_t   cls;
  logic             do_push, do_pop;

  // classify: words before the last count as full, last saturates at eight
  always_comb begin
    cls.word   = in_data_word;
    cls.last   = in_last;
    if (!in_last || in_valid_bytes > xxh_pkg::FULL_WORD_BYTES)
      cls.nbytes = xxh_pkg::FULL_WORD_BYTES;
    else
      cls.nbytes = in_valid_bytes;
  end

  assign in_full = (count_r == CW'(DEPTH));
  assign q_valid = (count_r != '0);
  assign q_item  = mem_r[rptr_r];
  assign do_push = in_push && !in_full;
  assign do_pop  = q_pop && q_valid;

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= cls;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) wptr_r <= (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      if (do_pop)  rptr_r <= (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

endmodule

// ===== hdl/xxh_mul.sv =====
// iterative 64x64 low-half multiplier built from one 32x32 partial product per cycle
module xxh_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  xxh_pkg::mul_req_t  req,
  output logic               done,
  output logic [63:0]        p
);

  logic [63:0] a_r, b_r, acc_r;
  logic [1:0]  ph_r;
  logic        busy_r, done_r;
  logic [31:0] op_x, op_y;
  logic [63:0] prod;

  // operand select per phase: lo*lo, lo*hi, hi*lo
  always_comb begin
    op_x = (ph_r == 2'd2) ? a_r[63:32] : a_r[31:0];
    op_y = (ph_r == 2'd1) ? b_r[63:32] : b_r[31:0];
    prod = {32'b0, op_x} * {32'b0, op_y};
  end

  assign done = done_r;
  assign p    = acc_r;

  // operand and accumulator registers
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r <= req.a;
      b_r <= req.b;
    end else if (busy_r) begin
      if (ph_r == 2'd0) acc_r <= prod;
      else              acc_r <= acc_r + {prod[31:0], 32'b0};
    end
  end

  // phase control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r   <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        ph_r   <= '0;
      end else if (busy_r) begin
        if (ph_r == 2'd2) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        ph_r <= ph_r + 1'b1;
      end
    end
  end

endmodule

// ===== hdl/xxh_back.sv =====
// hash sequencer: lane rounds, merge, tail folds, avalanche and result register
module xxh_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [63:0]        seed,
  input  logic               q_valid,
  input  xxh_pkg::item_t     q_item,
  output logic               q_pop,
  output xxh_pkg::mul_req_t  mreq,
  input  logic               mdone,
  input  logic [63:0]        mp,
  output logic               out_empty,
  output logic [63:0]        out_digest,
  input  logic               out_pop
);

  typedef enum logic [4:0] {
    S_IDLE, S_MW,
    S_LR_A, S_LR_B, S_LR_C,
    S_FIN0, S_MG_A, S_MG_B, S_MG_C, S_MG_D, S_ADDLEN,
    S_TAIL, S_F_A, S_F_B, S_F_C, S_F_D,
    S_WORD, S_W4_B, S_W4_C,
    S_BYTE, S_B_B, S_B_C,
    S_AVA, S_AV_B, S_AV_C, S_OUT
  } state_t;

  state_t      state_r, ret_r;
  logic [63:0] acc_r [4];
  logic [63:0] tail_r [3];
  logic [1:0]  pend_r;
  logic [63:0] total_r;
  logic        seen_r;
  logic [63:0] w_r, h_r, dig_r;
  logic [3:0]  n_r, k_r;
  logic [1:0]  idx_r;
  logic        fin_r, wfold_r, ovalid_r;
  logic [63:0] lane_word, fold_word, byte_val, hx;

  assign q_pop      = (state_r == S_IDLE) && q_valid;
  assign out_empty  = !ovalid_r;
  assign out_digest = dig_r;

  // operand views
  always_comb begin
    lane_word = (idx_r == 2'd3) ? w_r : tail_r[idx_r];
    fold_word = wfold_r ? w_r : tail_r[idx_r];
    byte_val  = {56'b0, w_r[8*k_r[2:0] +: 8]};
    hx        = h_r ^ mp;
  end

  // sequencer, hash state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ret_r      <= S_IDLE;
      pend_r     <= '0;
      total_r    <= '0;
      seen_r     <= 1'b0;
      ovalid_r   <= 1'b0;
      mreq.start <= 1'b0;
      fin_r      <= 1'b0;
      wfold_r    <= 1'b0;
      idx_r      <= '0;
      k_r        <= '0;
    end else begin
      mreq.start <= 1'b0;
      if (out_pop && ovalid_r) ovalid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            w_r   <= q_item.word;
            fin_r <= q_item.last;
            idx_r <= '0;
            total_r <= total_r + {60'b0, q_item.nbytes};
            if (pend_r == 2'd3 && q_item.nbytes == xxh_pkg::FULL_WORD_BYTES) begin
              // stripe completes; lanes are seeded on the first one
              n_r <= '0;
              if (!seen_r) begin
                acc_r[0] <= seed + xxh_pkg::P1 + xxh_pkg::P2;
                acc_r[1] <= seed + xxh_pkg::P2;
                acc_r[2] <= seed;
                acc_r[3] <= seed - xxh_pkg::P1;
                seen_r   <= 1'b1;
              end
              state_r <= S_LR_A;
            end else if (!q_item.last) begin
              tail_r[pend_r] <= q_item.word;
              pend_r <= pend_r + 1'b1;
            end else begin
              n_r     <= q_item.nbytes;
              state_r <= S_FIN0;
            end
          end
        end
        S_MW: if (mdone) state_r <= ret_r;
        // lane round over the four stripe words
        S_LR_A: begin
          mreq <= '{1'b1, lane_word, xxh_pkg::P2};
          ret_r <= S_LR_B; state_r <= S_MW;
        end
        S_LR_B: begin
          mreq <= '{1'b1, xxh_pkg::rotl(acc_r[idx_r] + mp, 31), xxh_pkg::P1};
          ret_r <= S_LR_C; state_r <= S_MW;
        end
        S_LR_C: begin
          acc_r[idx_r] <= mp;
          if (idx_r == 2'd3) begin
            pend_r  <= '0;
            idx_r   <= '0;
            state_r <= fin_r ? S_FIN0 : S_IDLE;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_LR_A;
          end
        end
        // merge lanes or start from the seed
        S_FIN0: begin
          idx_r <= '0;
          if (seen_r) begin
            h_r <= xxh_pkg::rotl(acc_r[0], 1) + xxh_pkg::rotl(acc_r[1], 7) +
                   xxh_pkg::rotl(acc_r[2], 12) + xxh_pkg::rotl(acc_r[3], 18);
            state_r <= S_MG_A;
          end else begin
            h_r     <= seed + xxh_pkg::P5;
            state_r <= S_ADDLEN;
          end
        end
        S_MG_A: begin
          mreq <= '{1'b1, acc_r[idx_r], xxh_pkg::P2};
          ret_r <= S_MG_B; state_r <= S_MW;
        end
        S_MG_B: begin
          mreq <= '{1'b1, xxh_pkg::rotl(mp, 31), xxh_pkg::P1};
          ret_r <= S_MG_C; state_r <= S_MW;
        end
        S_MG_C: begin
          mreq <= '{1'b1, hx, xxh_pkg::P1};
          ret_r <= S_MG_D; state_r <= S_MW;
        end
        S_MG_D: begin
          h_r <= mp + xxh_pkg::P4;
          if (idx_r == 2'd3) state_r <= S_ADDLEN;
          else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_MG_A;
          end
        end
        S_ADDLEN: begin
          h_r     <= h_r + total_r;
          idx_r   <= '0;
          wfold_r <= 1'b0;
          state_r <= S_TAIL;
        end
        // eight-byte folds of buffered words and of a full last word
        S_TAIL: state_r <= ({1'b0, idx_r} < {1'b0, pend_r}) ? S_F_A : S_WORD;
        S_F_A: begin
          mreq <= '{1'b1, fold_word, xxh_pkg::P2};
          ret_r <= S_F_B; state_r <= S_MW;
        end
        S_F_B: begin
          mreq <= '{1'b1, xxh_pkg::rotl(mp, 31), xxh_pkg::P1};
          ret_r <= S_F_C; state_r <= S_MW;
        end
        S_F_C: begin
          mreq <= '{1'b1, xxh_pkg::rotl(hx, 27), xxh_pkg::P1};
          ret_r <= S_F_D; state_r <= S_MW;
        end
        S_F_D: begin
          h_r <= mp + xxh_pkg::P4;
          if (wfold_r) state_r <= S_AVA;
          else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_TAIL;
          end
        end
        // last word: full fold, four-byte round or single bytes
        S_WORD: begin
          k_r <= '0;
          if (n_r == xxh_pkg::FULL_WORD_BYTES) begin
            wfold_r <= 1'b1;
            state_r <= S_F_A;
          end else if (n_r >= 4'd4) begin
            mreq <= '{1'b1, {32'b0, w_r[31:0]}, xxh_pkg::P1};
            ret_r <= S_W4_B; state_r <= S_MW;
          end else begin
            state_r <= S_BYTE;
          end
        end
        S_W4_B: begin
          mreq <= '{1'b1, xxh_pkg::rotl(hx, 23), xxh_pkg::P2};
          ret_r <= S_W4_C; state_r <= S_MW;
        end
        S_W4_C: begin
          h_r     <= mp + xxh_pkg::P3;
          k_r     <= 4'd4;
          state_r <= S_BYTE;
        end
        S_BYTE: begin
          if (k_r < n_r) begin
            mreq <= '{1'b1, byte_val, xxh_pkg::P5};
            ret_r <= S_B_B; state_r <= S_MW;
          end else begin
            state_r <= S_AVA;
          end
        end
        S_B_B: begin
          mreq <= '{1'b1, xxh_pkg::rotl(hx, 11), xxh_pkg::P1};
          ret_r <= S_B_C; state_r <= S_MW;
        end
        S_B_C: begin
          h_r     <= mp;
          k_r     <= k_r + 1'b1;
          state_r <= S_BYTE;
        end
        // avalanche
        S_AVA: begin
          mreq <= '{1'b1, h_r ^ (h_r >> 33), xxh_pkg::P2};
          ret_r <= S_AV_B; state_r <= S_MW;
        end
        S_AV_B: begin
          mreq <= '{1'b1, mp ^ (mp >> 29), xxh_pkg::P3};
          ret_r <= S_AV_C; state_r <= S_MW;
        end
        S_AV_C: begin
          h_r     <= mp ^ (mp >> 32);
          state_r <= S_OUT;
        end
        // hand the digest to the result register once it is free
        S_OUT: begin
          if (!ovalid_r || out_pop) begin
            dig_r    <= h_r;
            ovalid_r <= 1'b1;
            pend_r   <= '0;
            total_r  <= '0;
            seen_r   <= 1'b0;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/xxh64_stream_hash_unit.sv =====
// top level of the xxh64 stream hash unit
// Streams a message as little-endian 64-bit words and returns its XXH64 digest.
// Input channel: drive in_data_word, in_valid_bytes and in_last with in_push;
// a transaction happens on a clock edge with in_push high and in_full low.
// Only the word flagged by in_last may carry fewer than eight bytes.
// Result channel: while out_empty is low, out_digest holds the digest of the
// oldest finished message; out_pop high takes it.
// cfg_we with cfg_wdata writes the seed; write it only while the unit is idle.
// Flow: words go into an input queue of FIFO_DEPTH entries. A word that only
// lands in the tail buffer is handled by the sequencer in its idle state. Every
// product step through the shared multiplier runs through issue, operand load,
// three 32x32 partial products and the hand-back. A word that closes a 32-byte
// stripe takes eight product steps. The last word adds the lane merge (none when
// no stripe was seen), a fold per buffered tail word, and the final bytes and
// avalanche.
// Reset clears the queue, the message state and the result register; the
// seed returns to zero. If the result is not popped the sequencer holds the
// next digest and the input queue fills and raises in_full.
module xxh64_stream_hash_unit #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [63:0] in_data_word,
  input  logic [3:0]  in_valid_bytes,
  input  logic        in_last,
  output logic        out_empty,
  output logic [63:0] out_digest,
  input  logic        out_pop,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata
);

  logic              q_valid, q_pop, mdone;
  xxh_pkg::item_t    q_item;
  xxh_pkg::mul_req_t mreq;
  logic [63:0]       mp, seed_r;

  // seed register
  always_ff @(posedge clk) begin
    if (!rst_n)      seed_r <= '0;
    else if (cfg_we) seed_r <= cfg_wdata;
  end

  xxh_front #(.DEPTH(FIFO_DEPTH)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_data_word, .in_valid_bytes, .in_last,
    .q_valid, .q_item, .q_pop
  );

  xxh_mul u_mul (
    .clk, .rst_n, .req(mreq), .done(mdone), .p(mp)
  );

  xxh_back u_back (
    .clk, .rst_n, .seed(seed_r), .q_valid, .q_item, .q_pop,
    .mreq, .mdone, .mp, .out_empty, .out_digest, .out_pop
  );

endmodule

// ===== hdl/xxh_checker.sv =====
// port-level checks for the xxh64 stream hash unit and their bind
module xxh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_full,
  input logic        out_empty,
  input logic        out_pop,
  input logic [63:0] out_digest
);

  // reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result shown right after reset");

  // reset leaves the input queue open
  a_reset_open: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input full right after reset");

  // a waiting digest holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_digest)))
    else $error("waiting digest changed or dropped");

endmodule

bind xxh64_stream_hash_unit xxh_checker u_xxh_checker (
  .clk, .rst_n, .in_full, .out_empty, .out_pop, .out_digest
);

// ===== test/xxh64_stream_hash_unit_tb.sv =====
// testbench of the xxh64 stream hash unit: directed table, then random messages
`timescale 1ns / 100ps

module xxh64_stream_hash_unit_tb;

  localparam int WATCH_LIMIT = 6000;
  localparam int SETTLE_CYCLES = 250;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [63:0] in_data_word = '0;
  logic [3:0]  in_valid_bytes = '0;
  logic        in_last = 1'b0;
  logic        out_empty;
  logic [63:0] out_digest;
  logic        out_pop = 1'b0;
  logic        cfg_we = 1'b0;
  logic [63:0] cfg_wdata = '0;

  xxh64_stream_hash_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_data_word(in_data_word), .in_valid_bytes(in_valid_bytes), .in_last(in_last),
    .out_empty(out_empty), .out_digest(out_digest), .out_pop(out_pop),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // digest predictor state
  logic [63:0] hp_seed;
  logic [63:0] hp_lane [4];
  logic [63:0] hp_tail [3];
  int unsigned hp_pending;
  logic [63:0] hp_count;
  bit          hp_striped;

  logic [63:0] digest_q [$];
  int err_cnt = 0;
  int send_gap_pct = 0;
  int rx_stall_pct = 0;
  bit rx_hold = 1'b0;
  int idle_cycles = 0;

  function automatic logic [63:0] rl(input logic [63:0] v, input int s);
    logic [127:0] d;
    d = {v, v} << s;
    return d[127:64];
  endfunction

  function automatic logic [63:0] lane_mix(input logic [63:0] acc, input logic [63:0] w);
    return rl(acc + w * xxh_pkg::P2, 31) * xxh_pkg::P1;
  endfunction

  function automatic logic [63:0] tail_mix(input logic [63:0] h, input logic [63:0] w);
    return rl(h ^ lane_mix(64'd0, w), 27) * xxh_pkg::P1 + xxh_pkg::P4;
  endfunction

  function automatic void consume_stripe(input logic [63:0] w3);
    if (!hp_striped) begin
      hp_lane[0] = hp_seed + xxh_pkg::P1 + xxh_pkg::P2;
      hp_lane[1] = hp_seed + xxh_pkg::P2;
      hp_lane[2] = hp_seed;
      hp_lane[3] = hp_seed - xxh_pkg::P1;
      hp_striped = 1'b1;
    end
    for (int i = 0; i < 3; i++) hp_lane[i] = lane_mix(hp_lane[i], hp_tail[i]);
    hp_lane[3] = lane_mix(hp_lane[3], w3);
    hp_pending = 0;
  endfunction

  // advance the predictor by one word; returns 1 with a digest on the last word
  function automatic bit hash_word(input logic [63:0] w, input logic [3:0] vb,
                                   input logic lst, output logic [63:0] dg);
    logic [63:0] h;
    int n;
    n = vb;
    dg = '0;
    if (!lst) begin
      hp_count += 64'd8;
      if (hp_pending == 3) consume_stripe(w);
      else begin
        hp_tail[hp_pending] = w;
        hp_pending++;
      end
      return 1'b0;
    end
    if (n > 8) n = 8;
    hp_count += 64'(n);
    if (n == 8 && hp_pending == 3) begin
      consume_stripe(w);
      n = 0;
    end
    if (hp_striped) begin
      h = rl(hp_lane[0], 1) + rl(hp_lane[1], 7) + rl(hp_lane[2], 12) + rl(hp_lane[3], 18);
      for (int i = 0; i < 4; i++)
        h = (h ^ lane_mix(64'd0, hp_lane[i])) * xxh_pkg::P1 + xxh_pkg::P4;
    end else begin
      h = hp_seed + xxh_pkg::P5;
    end
    h += hp_count;
    for (int i = 0; i < hp_pending; i++) h = tail_mix(h, hp_tail[i]);
    if (n == 8) begin
      h = tail_mix(h, w);
    end else begin
      int k;
      k = 0;
      if (n >= 4) begin
        h ^= {32'd0, w[31:0]} * xxh_pkg::P1;
        h = rl(h, 23) * xxh_pkg::P2 + xxh_pkg::P3;
        k = 4;
      end
      for (; k < n; k++) begin
        h ^= {56'd0, w[8*k +: 8]} * xxh_pkg::P5;
        h = rl(h, 11) * xxh_pkg::P1;
      end
    end
    h ^= h >> 33; h *= xxh_pkg::P2;
    h ^= h >> 29; h *= xxh_pkg::P3;
    h ^= h >> 32;
    hp_pending = 0;
    hp_count = '0;
    hp_striped = 1'b0;
    dg = h;
    return 1'b1;
  endfunction

  // directed stimulus table
  typedef struct {
    logic [63:0] w;
    logic [3:0]  vb;
    logic        lst;
    bit          fixed;
    logic [63:0] dg;
  } row_t;

  row_t dir_tab [22] = '{
    // empty message, reset seed
    '{64'h0, 4'd0, 1'b1, 1'b1, 64'hEF46DB3751D8E999},
    '{64'hFFFFFFFFFFFFFFFF, 4'd1, 1'b1, 1'b0, 64'h0},
    '{64'h0000000000000000, 4'd4, 1'b1, 1'b0, 64'h0},
    '{64'hFFFFFFFFFFFFFFFF, 4'd7, 1'b1, 1'b0, 64'h0},
    '{64'h0123456789ABCDEF, 4'd8, 1'b1, 1'b0, 64'h0},
    // saturated byte counts
    '{64'hA5A5A5A5A5A5A5A5, 4'd9, 1'b1, 1'b0, 64'h0},
    '{64'h5A5A5A5A5A5A5A5A, 4'd15, 1'b1, 1'b0, 64'h0},
    // short count before the last word is ignored
    '{64'h1111111111111111, 4'd3, 1'b0, 1'b0, 64'h0},
    '{64'h2222222222222222, 4'd0, 1'b0, 1'b0, 64'h0},
    '{64'h3333333333333333, 4'd5, 1'b1, 1'b0, 64'h0},
    // exactly one stripe
    '{64'hFFFFFFFFFFFFFFFF, 4'd8, 1'b0, 1'b0, 64'h0},
    '{64'hFFFFFFFFFFFFFFFF, 4'd8, 1'b0, 1'b0, 64'h0},
    '{64'hFFFFFFFFFFFFFFFF, 4'd8, 1'b0, 1'b0, 64'h0},
    '{64'hFFFFFFFFFFFFFFFF, 4'd8, 1'b1, 1'b0, 64'h0},
    // stripe plus a partial tail
    '{64'h0, 4'd8, 1'b0, 1'b0, 64'h0},
    '{64'h0, 4'd8, 1'b0, 1'b0, 64'h0},
    '{64'h0, 4'd8, 1'b0, 1'b0, 64'h0},
    '{64'h0, 4'd8, 1'b0, 1'b0, 64'h0},
    '{64'hDEADBEEFCAFEF00D, 4'd8, 1'b0, 1'b0, 64'h0},
    '{64'h8000000000000001, 4'd6, 1'b1, 1'b0, 64'h0},
    // two-byte message, then another empty one
    '{64'h7F7F7F7F7F7F7F7F, 4'd2, 1'b1, 1'b0, 64'h0},
    '{64'h0, 4'd0, 1'b1, 1'b0, 64'h0}
  };

  // offer one word, wait for its transaction, predict
  task automatic send_word(input logic [63:0] w, input logic [3:0] vb, input logic lst,
                           input bit fixed, input logic [63:0] fixed_dg);
    logic [63:0] dg;
    while ($urandom_range(99) < send_gap_pct) begin
      in_push = 1'b0;
      @(negedge clk);
    end
    in_push = 1'b1;
    in_data_word = w;
    in_valid_bytes = vb;
    in_last = lst;
    @(posedge clk);
    while (in_full) @(posedge clk);
    if (hash_word(w, vb, lst, dg)) digest_q.push_back(fixed ? fixed_dg : dg);
    @(negedge clk);
  endtask

  task automatic send_message(input int nwords);
    logic [3:0] vb;
    for (int i = 0; i < nwords; i++) begin
      if (i == nwords - 1) begin
        vb = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
        send_word({$urandom, $urandom}, vb, 1'b1, 1'b0, 64'h0);
      end else begin
        vb = ($urandom_range(7) == 0) ? 4'($urandom_range(15)) : 4'd8;
        send_word({$urandom, $urandom}, vb, 1'b0, 1'b0, 64'h0);
      end
    end
  endtask

  // wait for the unit to drain, then write the seed
  task automatic write_seed(input logic [63:0] s);
    in_push = 1'b0;
    wait (digest_q.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = s;
    @(negedge clk);
    cfg_we = 1'b0;
    hp_seed = s;
  endtask

  task automatic random_phase(input int nitems, input int gap, input int stall);
    int sent;
    int len;
    send_gap_pct = gap;
    rx_stall_pct = stall;
    sent = 0;
    while (sent < nitems) begin
      len = ($urandom_range(19) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
      send_message(len);
      sent += len;
    end
  endtask

  // result side: random pop
  always @(negedge clk) begin
    out_pop <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  // digest check
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (digest_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected digest %h", out_digest);
      end else begin
        if (out_digest !== digest_q[0]) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("digest mismatch: expected %h actual %h", digest_q[0], out_digest);
        end
        void'(digest_q.pop_front());
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    hp_seed = '0;
    hp_pending = 0;
    hp_count = '0;
    hp_striped = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed part at reset seed
    foreach (dir_tab[i])
      send_word(dir_tab[i].w, dir_tab[i].vb, dir_tab[i].lst, dir_tab[i].fixed, dir_tab[i].dg);

    // no idling, with a long receiver hold that backs up the input
    write_seed(64'hFFFFFFFFFFFFFFFF);
    rx_hold = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        rx_hold = 1'b0;
      end
    join_none
    random_phase(500, 0, 0);

    // sender pauses until all digests are back
    in_push = 1'b0;
    wait (digest_q.size() == 0);
    @(negedge clk);

    write_seed({$urandom, $urandom});
    random_phase(500, 60, 0);
    write_seed(64'd1);
    random_phase(500, 0, 60);
    write_seed({$urandom, $urandom});
    random_phase(500, 16, 16);
    write_seed(64'd0);
    send_message(5);

    in_push = 1'b0;
    wait (digest_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_cnt == 0 && digest_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
